[rtl/core/ctab_pkg.sv]
// shared types and constants of the clipped tinted alpha blender
`default_nettype none

package ctab_pkg;

	localparam int CH_W       = 8;
	localparam int COORD_W    = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CH_W-1:0] CH_MAX = 8'hff;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE   = 3'd5;

	// drawing modes
	localparam logic MODE_FILL  = 1'b0;
	localparam logic MODE_IMAGE = 1'b1;

	// register reset values
	localparam logic [COORD_W-1:0]    RST_CLIP_LEFT   = 13'd0;
	localparam logic [COORD_W-1:0]    RST_CLIP_TOP    = 13'd0;
	localparam logic [COORD_W-1:0]    RST_CLIP_RIGHT  = 13'd4095;
	localparam logic [COORD_W-1:0]    RST_CLIP_BOTTOM = 13'd4095;
	localparam logic [CFG_DATA_W-1:0] RST_TINT_COLOR  = 32'hffff_ffff;

	typedef logic [CH_W-1:0] chan_t;

	// configuration, tint bytes red green blue alpha from index 0 up
	typedef struct packed {
		logic signed [COORD_W-1:0] clip_left;
		logic signed [COORD_W-1:0] clip_top;
		logic signed [COORD_W-1:0] clip_right;
		logic signed [COORD_W-1:0] clip_bottom;
		logic [3:0][CH_W-1:0]      tint;
		logic                      draw_mode;
	} cfg_t;

	// one input item
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [3:0][CH_W-1:0]      dst;
		logic [3:0][CH_W-1:0]      src;
	} pix_t;

	// one result item
	typedef struct packed {
		logic [3:0][CH_W-1:0] rgba;
		logic                 we;
	} res_t;

	// pipeline status towards the top level
	typedef struct packed {
		logic busy;
	} stat_t;

endpackage

`default_nettype wire

[rtl/core/clipped_tinted_alpha_blender_core.sv]
// clipped tinted alpha blender: an accepted item is registered through stages 1 to 4, and
// its result is valid out of stage 4; throughput one item per cycle unless m_tready is low
// and stalls the output, the four register stages of the blend pipeline each move whenever
// the stage after them is empty or moves
// asynchronous active-low reset empties the pipeline and loads register defaults
// configuration writes are taken in every cycle
`default_nettype none

module clipped_tinted_alpha_blender_core (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	// pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
	// src_red, src_green, src_blue, src_alpha, zero fill
	input  wire  [95:0] s_tdata,
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0] m_tdata,
	// write_enable
	output logic [0:0]  m_tuser
);
	import ctab_pkg::*;

	cfg_t  cfg_q;
	pix_t  pix;
	res_t  res;
	stat_t status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left   <= RST_CLIP_LEFT;
			cfg_q.clip_top    <= RST_CLIP_TOP;
			cfg_q.clip_right  <= RST_CLIP_RIGHT;
			cfg_q.clip_bottom <= RST_CLIP_BOTTOM;
			cfg_q.tint        <= RST_TINT_COLOR;
			cfg_q.draw_mode   <= MODE_FILL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data[COORD_W-1:0];
				REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data[COORD_W-1:0];
				REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data[COORD_W-1:0];
				REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data[COORD_W-1:0];
				REG_TINT_COLOR:  cfg_q.tint        <= cfg_data;
				REG_DRAW_MODE:   cfg_q.draw_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// unpack the input item
	assign pix.x      = s_tdata[12:0];
	assign pix.y      = s_tdata[25:13];
	assign pix.dst[0] = s_tdata[33:26];
	assign pix.dst[1] = s_tdata[41:34];
	assign pix.dst[2] = s_tdata[49:42];
	assign pix.dst[3] = s_tdata[57:50];
	assign pix.src[0] = s_tdata[65:58];
	assign pix.src[1] = s_tdata[73:66];
	assign pix.src[2] = s_tdata[81:74];
	assign pix.src[3] = s_tdata[89:82];

	ctab_blend_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pix    (pix),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.status    (status)
	);

	assign m_tdata    = res.rgba;
	assign m_tuser[0] = res.we;

	// a ready output side never stalls the input side
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although output side is ready");

	// an empty pipeline always takes an item
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy |-> s_tready)
		else $error("empty pipeline refused an item");

	// an accepted item is in flight in the next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> status.busy)
		else $error("accepted item lost from the pipeline");

endmodule

`default_nettype wire

[rtl/core/ctab_blend_pipe.sv]
// four stage blend pipeline: clip test, products, scaling, selection
`default_nettype none

module ctab_blend_pipe (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  ctab_pkg::pix_t   in_pix,
	input  ctab_pkg::cfg_t   cfg,
	output logic             out_valid,
	input  wire              out_ready,
	output ctab_pkg::res_t   out_res,
	output ctab_pkg::stat_t  status
);
	import ctab_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic go1, go2, go3, go4;

	// stage 1 registers
	logic [3:0][CH_W-1:0] d_s1;
	logic [2:0][CH_W-1:0] s_s1;
	chan_t                sa_s1;
	logic                 we_s1;
	// stage 2 registers
	logic [3:0][CH_W-1:0] d_s2;
	logic [2:0][15:0]     pa_s2;
	logic [2:0][15:0]     dm_s2;
	chan_t                sa_s2;
	logic                 we_s2;
	// stage 3 registers
	logic [3:0][CH_W-1:0] d_s3;
	logic [2:0][CH_W-1:0] fill_s3;
	logic [2:0][CH_W-1:0] img_a_s3;
	logic [2:0][CH_W-1:0] img_b_s3;
	logic                 we_s3;
	// stage 4 registers
	logic [3:0][CH_W-1:0] rgba_s4;
	logic                 we_s4;

	chan_t       ta;
	logic [15:0] sa_w;
	logic        we_w;
	chan_t       w_alpha;

	assign ta = cfg.tint[3];

	// a stage loads when it is empty or the next one moves
	assign go4      = !v_s4 || out_ready;
	assign go3      = !v_s3 || go4;
	assign go2      = !v_s2 || go3;
	assign go1      = !v_s1 || go2;
	assign in_ready = go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (go1) v_s1 <= in_valid;
			if (go2) v_s2 <= v_s1;
			if (go3) v_s3 <= v_s2;
			if (go4) v_s4 <= v_s3;
		end
	end

	// clip test and tinted source alpha
	assign sa_w = 16'(in_pix.src[3]) * 16'(ta);
	assign we_w = (ta != '0) &&
		(in_pix.x >= cfg.clip_left) && (in_pix.x < cfg.clip_right) &&
		(in_pix.y >= cfg.clip_top) && (in_pix.y < cfg.clip_bottom);

	always_ff @(posedge clk) begin
		if (go1) begin
			d_s1  <= in_pix.dst;
			s_s1  <= in_pix.src[2:0];
			sa_s1 <= sa_w[15:8];
			we_s1 <= we_w;
		end
	end

	// weight of the destination term
	assign w_alpha = (cfg.draw_mode == MODE_IMAGE) ? sa_s1 : ta;

	// colour and destination products
	always_ff @(posedge clk) begin
		if (go2) begin
			for (int k = 0; k < 3; k++) begin
				if (cfg.draw_mode == MODE_IMAGE)
					pa_s2[k] <= 16'(s_s1[k]) * 16'(cfg.tint[k]);
				else
					pa_s2[k] <= 16'(cfg.tint[k]) * 16'(ta);
				dm_s2[k] <= 16'(d_s1[k]) * 16'(CH_MAX - w_alpha);
			end
			d_s2  <= d_s1;
			sa_s2 <= sa_s1;
			we_s2 <= we_s1;
		end
	end

	// fill sum, and source scaling by the tinted alpha
	always_ff @(posedge clk) begin
		logic [16:0] sum;
		logic [23:0] prod;
		if (go3) begin
			for (int k = 0; k < 3; k++) begin
				sum          = {1'b0, pa_s2[k]} + {1'b0, dm_s2[k]};
				prod         = 24'(pa_s2[k]) * 24'(sa_s2);
				fill_s3[k]  <= sum[15:8];
				img_a_s3[k] <= prod[23:16];
				img_b_s3[k] <= dm_s2[k][15:8];
			end
			d_s3  <= d_s2;
			we_s3 <= we_s2;
		end
	end

	// final selection and saturation
	always_ff @(posedge clk) begin
		logic [CH_W:0]        isum;
		logic [3:0][CH_W-1:0] rgba_nxt;
		if (go4) begin
			rgba_nxt = d_s3;
			if (we_s3) begin
				if (cfg.draw_mode == MODE_FILL) begin
					if (ta == CH_MAX) begin
						rgba_nxt = cfg.tint;
					end else begin
						for (int k = 0; k < 3; k++)
							rgba_nxt[k] = fill_s3[k];
					end
				end else begin
					for (int k = 0; k < 3; k++) begin
						isum = {1'b0, img_a_s3[k]} + {1'b0, img_b_s3[k]};
						rgba_nxt[k] = isum[CH_W] ? CH_MAX : isum[CH_W-1:0];
					end
				end
			end
			rgba_s4 <= rgba_nxt;
			we_s4   <= we_s3;
		end
	end

	assign out_valid    = v_s4;
	assign out_res.rgba = rgba_s4;
	assign out_res.we   = we_s4;
	assign status.busy  = v_s1 || v_s2 || v_s3 || v_s4;

endmodule

`default_nettype wire

[test/clipped_tinted_alpha_blender_core_test.sv]
// self-checking testbench of the clipped tinted alpha blender core
`default_nettype none

module clipped_tinted_alpha_blender_core_test;

	import ctab_pkg::*;

	// register indexes past the end of the list, writes to them are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 50;
	localparam int STEADY_PHASE = 3;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	// one line of the directed table
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          data;
		pix_t                 pix;
		logic                 typed;
		res_t                 fixed;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	// shadow copy of the register file
	logic signed [COORD_W-1:0] clip_l;
	logic signed [COORD_W-1:0] clip_t;
	logic signed [COORD_W-1:0] clip_r;
	logic signed [COORD_W-1:0] clip_b;
	logic [3:0][CH_W-1:0]      tint;
	logic                      mode;

	res_t  blended[$];
	row_t  directed[$];
	int    mismatches;
	int    idle_cycles;
	bit    steady;
	string chan_name[4] = '{"red", "green", "blue", "alpha"};

	clipped_tinted_alpha_blender_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// new destination pixel and write enable for one item
	function automatic res_t predict_pixel(pix_t p);
		res_t        r;
		int unsigned a, sa, c, d, s, v;
		int          k;
		r.rgba = p.dst;
		a = tint[3];
		r.we = ($signed(p.x) >= clip_l) && ($signed(p.x) < clip_r) &&
			($signed(p.y) >= clip_t) && ($signed(p.y) < clip_b) && (a != 0);
		if (r.we) begin
			if (mode == MODE_FILL) begin
				if (tint[3] == CH_MAX) begin
					r.rgba = tint;
				end else begin
					for (k = 0; k < 3; k++) begin
						c = tint[k];
						d = p.dst[k];
						v = (c * a + d * (255 - a)) >> 8;
						r.rgba[k] = v[7:0];
					end
				end
			end else begin
				sa = (p.src[3] * a) >> 8;
				for (k = 0; k < 3; k++) begin
					s = p.src[k];
					c = tint[k];
					d = p.dst[k];
					v = ((s * c * sa) >> 16) + ((d * (255 - sa)) >> 8);
					if (v > 255)
						v = 255;
					r.rgba[k] = v[7:0];
				end
			end
		end
		return r;
	endfunction

	function automatic logic [95:0] pack_pixel(pix_t p);
		return {6'b0, p.src[3], p.src[2], p.src[1], p.src[0],
			p.dst[3], p.dst[2], p.dst[1], p.dst[0], p.y, p.x};
	endfunction

	function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic row_t pix_row(int x, int y, logic [31:0] dst, logic [31:0] src);
		row_t r;
		r = '0;
		r.kind = ROW_PIX;
		r.pix.x = 13'(x);
		r.pix.y = 13'(y);
		r.pix.dst = dst;
		r.pix.src = src;
		return r;
	endfunction

	function automatic row_t pix_row_exp(int x, int y, logic [31:0] dst, logic [31:0] src,
			logic [31:0] rgba, logic we);
		row_t r;
		r = pix_row(x, y, dst, src);
		r.typed = 1'b1;
		r.fixed.rgba = rgba;
		r.fixed.we = we;
		return r;
	endfunction

	// coordinate near a clip bound, inside the span, or anywhere
	function automatic logic [COORD_W-1:0] rand_coord(int lo, int hi);
		logic [COORD_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = 13'($urandom);
			1: v = 13'(lo + $urandom_range(0, 4) - 2);
			2: v = 13'(hi + $urandom_range(0, 4) - 2);
			default: v = (hi > lo) ? 13'(lo + $urandom_range(0, hi - lo - 1)) : 13'($urandom);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CLIP_LEFT:   clip_l = data[COORD_W-1:0];
			REG_CLIP_TOP:    clip_t = data[COORD_W-1:0];
			REG_CLIP_RIGHT:  clip_r = data[COORD_W-1:0];
			REG_CLIP_BOTTOM: clip_b = data[COORD_W-1:0];
			REG_TINT_COLOR:  tint = data;
			REG_DRAW_MODE:   mode = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one item, with random gaps in front of it outside the steady phase
	task automatic send_pixel(pix_t p, logic typed, res_t fixed);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_pixel(p);
		do @(posedge clk); while (!s_tready);
		blended.push_back(typed ? fixed : predict_pixel(p));
	endtask

	// hold the sender until every expected item is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (blended.size() != 0)
			@(posedge clk);
	endtask

	// random register setting for one phase, extremes and empty rectangles included
	task automatic setup_random(int ph);
		int          l, t, r, b;
		logic [31:0] data;
		logic [7:0]  ta;
		case (ph)
			0: begin
				l = -4096; t = -4096; r = 4095; b = 4095;
			end
			5: begin
				l = $urandom_range(0, 8191) - 4096;
				t = $urandom_range(0, 8191) - 4096;
				r = l - $urandom_range(0, 20);
				b = t + $urandom_range(0, 20);
			end
			default: begin
				l = $urandom_range(0, 8191) - 4096;
				t = $urandom_range(0, 8191) - 4096;
				r = l + $urandom_range(1, 300);
				b = t + $urandom_range(1, 300);
				if (r > 4095) r = 4095;
				if (b > 4095) b = 4095;
			end
		endcase
		data = $urandom; data[COORD_W-1:0] = 13'(l);
		cfg_write(REG_CLIP_LEFT, data);
		data = $urandom; data[COORD_W-1:0] = 13'(t);
		cfg_write(REG_CLIP_TOP, data);
		data = $urandom; data[COORD_W-1:0] = 13'(r);
		cfg_write(REG_CLIP_RIGHT, data);
		data = $urandom; data[COORD_W-1:0] = 13'(b);
		cfg_write(REG_CLIP_BOTTOM, data);
		case ($urandom_range(0, 7))
			0: ta = 8'h00;
			1, 2: ta = CH_MAX;
			default: ta = 8'($urandom);
		endcase
		data = $urandom; data[31:24] = ta;
		cfg_write(REG_TINT_COLOR, data);
		data = $urandom; data[0] = ph[0];
		cfg_write(REG_DRAW_MODE, data);
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6, $urandom);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 20);
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin : check_results
		res_t        want;
		logic [3:0][CH_W-1:0] got;
		int          k;
		if (arst_n && m_tvalid && m_tready) begin
			if (blended.size() == 0) begin
				report_mismatch("result with nothing expected, we", m_tuser[0], 0);
			end else begin
				want = blended.pop_front();
				got = m_tdata;
				for (k = 0; k < 4; k++)
					if (got[k] !== want.rgba[k])
						report_mismatch(chan_name[k], got[k], want.rgba[k]);
				if (m_tuser[0] !== want.we)
					report_mismatch("write_enable", m_tuser[0], want.we);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		pix_t p;
		row_t row;
		int   ph, n, i;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		clip_l = RST_CLIP_LEFT;
		clip_t = RST_CLIP_TOP;
		clip_r = RST_CLIP_RIGHT;
		clip_b = RST_CLIP_BOTTOM;
		tint = RST_TINT_COLOR;
		mode = MODE_FILL;

		// after reset: opaque white fill, clip from the origin up to 4094
		directed.push_back(pix_row_exp(0, 0, 32'h1122_3344, 32'h5566_7788, 32'hffff_ffff, 1'b1));
		directed.push_back(pix_row_exp(4094, 4094, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
		directed.push_back(pix_row_exp(4095, 10, 32'h0102_0304, 32'h0, 32'h0102_0304, 1'b0));
		directed.push_back(pix_row_exp(-1, 0, 32'ha0b0_c0d0, 32'h0, 32'ha0b0_c0d0, 1'b0));
		directed.push_back(pix_row_exp(0, -4096, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 1'b0));
		directed.push_back(pix_row_exp(10, 4095, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b0));
		// tint alpha zero writes nothing
		directed.push_back(cfg_row(REG_TINT_COLOR, 32'h0080_4020));
		directed.push_back(pix_row_exp(5, 5, 32'h1234_5678, 32'hffff_ffff, 32'h1234_5678, 1'b0));
		// partly transparent fill, source ignored
		directed.push_back(cfg_row(REG_TINT_COLOR, 32'h8090_6030));
		directed.push_back(pix_row(100, 200, 32'h1020_3040, 32'hffff_ffff));
		directed.push_back(pix_row(4094, 0, 32'hffff_ffff, 32'h0));
		directed.push_back(pix_row(0, 4094, 32'h0, 32'h1234_5678));
		directed.push_back(cfg_row(REG_TINT_COLOR, 32'h01ff_ffff));
		directed.push_back(pix_row(1, 1, 32'hffff_ffff, 32'h0));
		// image blit with white tint, transparent and opaque sources
		directed.push_back(cfg_row(REG_DRAW_MODE, 32'h0000_0001));
		directed.push_back(cfg_row(REG_TINT_COLOR, 32'hffff_ffff));
		directed.push_back(pix_row(2, 3, 32'h80ff_4000, 32'h00ff_ffff));
		directed.push_back(pix_row(3, 2, 32'h0, 32'hffff_ffff));
		directed.push_back(pix_row(4, 4, 32'hffff_ffff, 32'hffff_ffff));
		directed.push_back(pix_row(6, 6, 32'h4050_6070, 32'h8010_2030));
		directed.push_back(cfg_row(REG_TINT_COLOR, 32'h00ff_ffff));
		directed.push_back(pix_row_exp(7, 7, 32'hcafe_1234, 32'hffff_ffff, 32'hcafe_1234, 1'b0));
		// widest clip rectangle, upper data bits are junk and must be masked
		directed.push_back(cfg_row(REG_CLIP_LEFT, 32'hdead_f000));
		directed.push_back(cfg_row(REG_CLIP_TOP, 32'hdead_f000));
		directed.push_back(cfg_row(REG_CLIP_RIGHT, 32'hbeef_efff));
		directed.push_back(cfg_row(REG_CLIP_BOTTOM, 32'hbeef_efff));
		directed.push_back(cfg_row(REG_TINT_COLOR, 32'hffff_ffff));
		directed.push_back(cfg_row(REG_DRAW_MODE, 32'hffff_fffe));
		directed.push_back(pix_row_exp(-4096, -4096, 32'h0, 32'h0, 32'hffff_ffff, 1'b1));
		directed.push_back(pix_row_exp(4094, -4096, 32'h1111_1111, 32'h0, 32'hffff_ffff, 1'b1));
		directed.push_back(pix_row_exp(4095, 0, 32'h2222_2222, 32'h0, 32'h2222_2222, 1'b0));
		// empty clip, then writes to spare indexes that change nothing
		directed.push_back(cfg_row(REG_CLIP_LEFT, 32'd100));
		directed.push_back(cfg_row(REG_CLIP_RIGHT, 32'd100));
		directed.push_back(pix_row_exp(100, 0, 32'h3333_3333, 32'h0, 32'h3333_3333, 1'b0));
		directed.push_back(cfg_row(REG_SPARE_6, 32'hffff_ffff));
		directed.push_back(cfg_row(REG_SPARE_7, 32'hffff_ffff));
		directed.push_back(pix_row_exp(100, 0, 32'h4444_4444, 32'h0, 32'h4444_4444, 1'b0));
		directed.push_back(cfg_row(REG_CLIP_RIGHT, 32'd101));
		directed.push_back(pix_row_exp(100, 5, 32'h5555_5555, 32'h0, 32'hffff_ffff, 1'b1));
		// vertically empty clip
		directed.push_back(cfg_row(REG_CLIP_TOP, 32'd5));
		directed.push_back(cfg_row(REG_CLIP_BOTTOM, 32'd3));
		directed.push_back(pix_row_exp(100, 4, 32'h6666_6666, 32'h0, 32'h6666_6666, 1'b0));

		// reset
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (i = 0; i < directed.size(); i++) begin
			row = directed[i];
			if (row.kind == ROW_CFG) begin
				drain_results();
				cfg_write(row.idx, row.data);
			end else begin
				send_pixel(row.pix, row.typed, row.fixed);
			end
		end

		// random phases, one register setting each
		for (ph = 0; ph < PHASES; ph++) begin
			drain_results();
			setup_random(ph);
			steady = (ph == STEADY_PHASE);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				p.x = rand_coord(int'(clip_l), int'(clip_r));
				p.y = rand_coord(int'(clip_t), int'(clip_b));
				p.dst = $urandom;
				p.src = $urandom;
				send_pixel(p, 1'b0, '0);
			end
			steady = 1'b0;
		end

		// wait for the pipeline to empty
		drain_results();
		repeat (8) @(posedge clk);
		if (blended.size() != 0)
			report_mismatch("items still expected", 0, blended.size());
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
